FILE: hdl/nae_pkg.sv
// ----------------------------------------------------------------------------
// nae_pkg
// Shared types and constants of the perspective accumulator / evaluator.
// ----------------------------------------------------------------------------
package nae_pkg;

  // HID and STK must be powers of two: addresses are {row, neuron}
  localparam int HID      = 256;
  localparam int HID_W    = $clog2(HID);
  localparam int STK      = 128;
  localparam int TOP_W    = $clog2(STK);
  localparam int FEAT     = 768;
  localparam int FEAT_W   = 10;
  localparam int COLOR_STRIDE = 64 * 6;
  localparam int RANK_FLIP    = 56;
  localparam int HW_DEPTH = FEAT * HID;
  localparam int HW_AW    = FEAT_W + HID_W;
  localparam int OW_DEPTH = 2 * HID;
  localparam int OW_AW    = HID_W + 1;
  localparam int STK_DEPTH_W = STK * HID;
  localparam int STK_AW   = TOP_W + HID_W;
  localparam int IDX_W    = 18;
  localparam int DIV_W    = 50;
  localparam int DVS_W    = 20;
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    REQ_LOAD_HW  = 3'd0,
    REQ_LOAD_B   = 3'd1,
    REQ_LOAD_OW  = 3'd2,
    REQ_RESTART  = 3'd3,
    REQ_ADD      = 3'd4,
    REQ_PUSH     = 3'd5,
    REQ_POP      = 3'd6,
    REQ_EVAL     = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    CFG_OUT_BIAS       = 3'd0,
    CFG_CLAMP_MAX      = 3'd1,
    CFG_FIRST_DIVISOR  = 3'd2,
    CFG_EVAL_SCALE     = 3'd3,
    CFG_SECOND_DIVISOR = 3'd4,
    CFG_SCORE_LIMIT    = 3'd5
  } cfg_idx_e;

  // execution engine control states
  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_SWEEP, ST_DIV1, ST_WAIT1, ST_MUL, ST_DIV2, ST_WAIT2
  } state_e;

  typedef enum logic [1:0] {
    PASS_COPY, PASS_BIAS, PASS_FEAT, PASS_EVAL
  } pass_e;

  typedef struct packed {
    logic [15:0] out_bias;
    logic [14:0] clamp_max;
    logic [15:0] first_divisor;
    logic [15:0] eval_scale;
    logic [19:0] second_divisor;
    logic [14:0] score_limit;
  } cfg_t;

  // classified command word; feature slots 0,1 subtract and 2,3 add
  typedef struct packed {
    req_e                   op;
    logic                   load_ok;
    logic [IDX_W-1:0]       load_index;
    logic [15:0]            load_value;
    logic [3:0]             feat_en;
    logic [3:0][FEAT_W-1:0] wrow;
    logic [3:0][FEAT_W-1:0] brow;
    logic                   stm;
  } cmd_t;

endpackage

FILE: hdl/nae_front.sv
// ----------------------------------------------------------------------------
// nae_front
// Decodes an incoming word into a command: range checks and feature rows.
// ----------------------------------------------------------------------------
module nae_front (
  input  logic [2:0]            req_type_i,
  input  logic [1:0]            move_kind_i,
  input  logic [9:0]            sub_first_i,
  input  logic [9:0]            sub_second_i,
  input  logic [9:0]            add_first_i,
  input  logic [9:0]            add_second_i,
  input  logic                  side_to_move_i,
  input  logic [17:0]           load_index_i,
  input  logic signed [15:0]    load_value_i,
  output nae_pkg::cmd_t         cmd_o
);
  import nae_pkg::*;

  // black-view row: swap color, flip rank
  function automatic logic [FEAT_W-1:0] mirror(input logic [FEAT_W-1:0] f);
    logic [FEAT_W-1:0] r;
    begin
      r = (f >= FEAT_W'(COLOR_STRIDE)) ? f - FEAT_W'(COLOR_STRIDE)
                                       : f + FEAT_W'(COLOR_STRIDE);
      return r ^ FEAT_W'(RANK_FLIP);
    end
  endfunction

  req_e                   op;
  logic                   is_push;
  logic [3:0][FEAT_W-1:0] feat;
  logic [3:0]             in_range;

  assign op      = req_e'(req_type_i);
  assign is_push = (op == REQ_PUSH);
  assign feat[0] = sub_first_i;
  assign feat[1] = sub_second_i;
  assign feat[2] = add_first_i;
  assign feat[3] = add_second_i;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      in_range[k]    = (feat[k] < FEAT_W'(FEAT));
      cmd_o.wrow[k]  = feat[k];
      cmd_o.brow[k]  = mirror(feat[k]);
    end
    cmd_o.op         = op;
    cmd_o.load_index = load_index_i;
    cmd_o.load_value = load_value_i;
    cmd_o.stm        = side_to_move_i;
    cmd_o.feat_en[0] = is_push & in_range[0];
    cmd_o.feat_en[1] = is_push & (move_kind_i != 2'd0) & in_range[1];
    cmd_o.feat_en[2] = (is_push | (op == REQ_ADD)) & in_range[2];
    cmd_o.feat_en[3] = is_push & move_kind_i[1] & in_range[3];
    unique case (op)
      REQ_LOAD_HW: cmd_o.load_ok = (32'(load_index_i) < HW_DEPTH);
      REQ_LOAD_B:  cmd_o.load_ok = (32'(load_index_i) < HID);
      REQ_LOAD_OW: cmd_o.load_ok = (32'(load_index_i) < OW_DEPTH);
      default:     cmd_o.load_ok = 1'b0;
    endcase
  end

endmodule

FILE: hdl/nae_fifo.sv
// ----------------------------------------------------------------------------
// nae_fifo
// Short command queue between the decoder and the execution engine.
// ----------------------------------------------------------------------------
module nae_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nae_pkg::cmd_t din_i,
  input  logic          pop_i,
  output nae_pkg::cmd_t dout_o,
  output logic          full_o,
  output logic          empty_o
);
  import nae_pkg::*;

  cmd_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= din_i;
  end

endmodule

FILE: hdl/nae_div.sv
// ----------------------------------------------------------------------------
// nae_div
// Signed by unsigned divider, truncating toward zero, one bit per cycle.
// ----------------------------------------------------------------------------
module nae_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [nae_pkg::DIV_W-1:0]      dividend_i,
  input  logic [nae_pkg::DVS_W-1:0]      divisor_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [nae_pkg::DIV_W-1:0]      quot_o
);
  import nae_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] mag_q, quot_q, res;
  logic [DVS_W-1:0] rem_q, den_q, rem_d;
  logic [DVS_W:0]   trial;
  logic             qbit;

  assign trial = {rem_q, mag_q[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, den_q});
  assign rem_d = qbit ? DVS_W'(trial - {1'b0, den_q}) : trial[DVS_W-1:0];
  assign res   = {mag_q[DIV_W-2:0], qbit};

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      mag_q <= dividend_i[DIV_W-1] ? DIV_W'(0) - dividend_i : dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      mag_q <= res;
      if (cnt_q == CNT_W'(1)) quot_q <= neg_q ? DIV_W'(0) - res : res;
    end
  end

endmodule

FILE: hdl/nae_back.sv
// ----------------------------------------------------------------------------
// nae_back
// Execution engine: weight stores, accumulator stacks, neuron sweeps and the
// output layer arithmetic.
// ----------------------------------------------------------------------------
module nae_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nae_pkg::cfg_t       cfg_i,
  input  logic                fifo_empty_i,
  input  nae_pkg::cmd_t       cmd_i,
  output logic                fifo_pop_o,
  output logic                done_o,
  output logic signed [15:0]  score_o,
  output logic                stack_error_o
);
  import nae_pkg::*;

  // per-neuron phases
  localparam logic [2:0] PH_ISSUE = 3'd0;
  localparam logic [2:0] PH_LATCH = 3'd1;
  localparam logic [2:0] PH_WRITE = 3'd2;
  localparam logic [2:0] PH_MUL   = 3'd3;
  localparam logic [2:0] PH_ACC   = 3'd4;
  localparam logic [TOP_W-1:0] TOP_MAX = TOP_W'(STK - 1);
  localparam logic [HID_W-1:0] N_LAST  = HID_W'(HID - 1);

  function automatic logic [1:0] first_bit(input logic [3:0] m);
    logic [1:0] r;
    begin
      r = 2'd3;
      for (int k = 3; k >= 0; k--) if (m[k]) r = 2'(k);
      return r;
    end
  endfunction

  function automatic logic [14:0] clamp_act(input logic [15:0] v,
                                            input logic [14:0] cmax);
    begin
      if (v[15])              return 15'd0;
      else if (v[14:0] > cmax) return cmax;
      else                    return v[14:0];
    end
  endfunction

  state_e            state_q, state_d;
  pass_e             pass_q;
  cmd_t              cmd_q;
  logic [3:0]        mask_q, mask_nx;
  logic [1:0]        fi_q;
  logic [HID_W-1:0]  n_q;
  logic [2:0]        ph_q;
  logic [TOP_W-1:0]  top_q, src_q, rd_row;
  logic              err_q, done_q, serr_q;
  logic [15:0]       score_q;
  logic [31:0]       sum_q, t0_q, t1_q;
  logic [15:0]       sw_q, sb_q, wt_q, bias_q, ow0_q, ow1_q;
  logic [29:0]       sq0_q, sq1_q;
  logic [DIV_W-1:0]  prod_q;
  logic              neuron_end, sweep_last;

  // memories
  logic [15:0] hw_mem  [HW_DEPTH];
  logic [15:0] b_mem   [HID];
  logic [15:0] ow_mem  [OW_DEPTH];
  logic [15:0] ws_mem  [STK_DEPTH_W];
  logic [15:0] bs_mem  [STK_DEPTH_W];
  logic [15:0] hw_rd_q, b_rd_q, ow_rd_q, ws_rd_q, bs_rd_q;
  logic [HW_AW-1:0]  hw_ra;
  logic [OW_AW-1:0]  ow_ra;
  logic [STK_AW-1:0] st_ra, st_wa;
  logic              st_we;
  logic [15:0]       ws_wd, bs_wd;

  // datapath
  logic [15:0]        own, oth;
  logic [14:0]        a0, a1;
  logic signed [46:0] m0, m1;
  logic signed [33:0] biased;
  logic signed [50:0] scaled;
  logic [DIV_W-1:0]   lim, nlim, q2;
  logic [15:0]        score_d;

  logic              div_start, div_busy, div_done;
  logic [DIV_W-1:0]  div_num, div_q;
  logic [DVS_W-1:0]  div_den, d1, d2;

  assign neuron_end = (pass_q == PASS_EVAL) ? (ph_q == PH_ACC) : (ph_q == PH_WRITE);
  assign sweep_last = neuron_end && (n_q == N_LAST);
  assign mask_nx    = (pass_q == PASS_FEAT) ? (mask_q & ~(4'b0001 << fi_q)) : mask_q;

  // ---------------- control FSM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    fifo_pop_o = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          fifo_pop_o = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (cmd_q.op)
          REQ_RESTART, REQ_EVAL: state_d = ST_SWEEP;
          REQ_ADD:  state_d = (cmd_q.feat_en != 4'd0) ? ST_SWEEP : ST_IDLE;
          REQ_PUSH: state_d = (top_q == TOP_MAX) ? ST_IDLE : ST_SWEEP;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_SWEEP: begin
        if (sweep_last) begin
          if (pass_q == PASS_EVAL)  state_d = ST_DIV1;
          else if (mask_nx == 4'd0) state_d = ST_IDLE;
        end
      end
      ST_DIV1: begin
        div_start = 1'b1;
        state_d   = ST_WAIT1;
      end
      ST_WAIT1: if (div_done) state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIV2;
      ST_DIV2: begin
        div_start = 1'b1;
        state_d   = ST_WAIT2;
      end
      ST_WAIT2: if (div_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= PASS_COPY;
      mask_q <= '0;
      fi_q   <= '0;
      n_q    <= '0;
      ph_q   <= PH_ISSUE;
      top_q  <= '0;
      err_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_DECODE: begin
          n_q    <= '0;
          ph_q   <= PH_ISSUE;
          mask_q <= '0;
          case (cmd_q.op)
            REQ_RESTART: begin
              top_q  <= '0;
              pass_q <= PASS_BIAS;
            end
            REQ_ADD: begin
              pass_q <= PASS_FEAT;
              mask_q <= cmd_q.feat_en;
              fi_q   <= first_bit(cmd_q.feat_en);
            end
            REQ_PUSH: begin
              if (top_q == TOP_MAX) begin
                err_q <= 1'b1;
              end else begin
                top_q  <= top_q + 1'b1;
                pass_q <= PASS_COPY;
                mask_q <= cmd_q.feat_en;
              end
            end
            REQ_POP: begin
              if (top_q == '0) err_q <= 1'b1;
              else             top_q <= top_q - 1'b1;
            end
            REQ_EVAL: pass_q <= PASS_EVAL;
            default: ;
          endcase
        end
        ST_SWEEP: begin
          if (neuron_end) begin
            ph_q <= PH_ISSUE;
            n_q  <= n_q + 1'b1;
            if (n_q == N_LAST && pass_q != PASS_EVAL) begin
              mask_q <= mask_nx;
              pass_q <= PASS_FEAT;
              fi_q   <= first_bit(mask_nx);
            end
          end else begin
            ph_q <= ph_q + 1'b1;
          end
        end
        ST_WAIT2: if (div_done) done_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // ---------------- neuron datapath
  assign own = cmd_q.stm ? sb_q : sw_q;
  assign oth = cmd_q.stm ? sw_q : sb_q;
  assign a0  = clamp_act(own, cfg_i.clamp_max);
  assign a1  = clamp_act(oth, cfg_i.clamp_max);
  assign m0  = $signed({1'b0, sq0_q}) * $signed(ow0_q);
  assign m1  = $signed({1'b0, sq1_q}) * $signed(ow1_q);

  always_ff @(posedge clk_i) begin
    if (fifo_pop_o) cmd_q <= cmd_i;
    if (state_q == ST_DECODE) begin
      src_q <= top_q;
      sum_q <= '0;
    end
    if (state_q == ST_SWEEP) begin
      case (ph_q)
        PH_LATCH: begin
          sw_q   <= ws_rd_q;
          sb_q   <= bs_rd_q;
          wt_q   <= hw_rd_q;
          bias_q <= b_rd_q;
          ow0_q  <= ow_rd_q;
        end
        PH_WRITE: begin
          sq0_q <= 30'(a0) * 30'(a0);
          sq1_q <= 30'(a1) * 30'(a1);
          ow1_q <= ow_rd_q;
        end
        PH_MUL: begin
          t0_q <= m0[31:0];
          t1_q <= m1[31:0];
        end
        PH_ACC: sum_q <= sum_q + t0_q + t1_q;
        default: ;
      endcase
    end
    if (state_q == ST_MUL) prod_q <= scaled[DIV_W-1:0];
    if (state_q == ST_WAIT2 && div_done) begin
      score_q <= score_d;
      serr_q  <= err_q;
    end
  end

  // ---------------- memories
  assign rd_row = (pass_q == PASS_COPY) ? src_q : top_q;
  assign st_ra  = {rd_row, n_q};
  assign st_wa  = {top_q, n_q};
  assign hw_ra  = (ph_q == PH_ISSUE) ? {cmd_q.wrow[fi_q], n_q} : {cmd_q.brow[fi_q], n_q};
  assign ow_ra  = {(ph_q != PH_ISSUE), n_q};
  assign st_we  = (state_q == ST_SWEEP) && (ph_q == PH_WRITE) && (pass_q != PASS_EVAL);

  always_comb begin
    case (pass_q)
      PASS_BIAS: begin
        ws_wd = bias_q;
        bs_wd = bias_q;
      end
      PASS_FEAT: begin
        ws_wd = fi_q[1] ? sw_q + wt_q    : sw_q - wt_q;
        bs_wd = fi_q[1] ? sb_q + hw_rd_q : sb_q - hw_rd_q;
      end
      default: begin
        ws_wd = sw_q;
        bs_wd = sb_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECODE && cmd_q.op == REQ_LOAD_HW && cmd_q.load_ok)
      hw_mem[cmd_q.load_index[HW_AW-1:0]] <= cmd_q.load_value;
    hw_rd_q <= hw_mem[hw_ra];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECODE && cmd_q.op == REQ_LOAD_B && cmd_q.load_ok)
      b_mem[cmd_q.load_index[HID_W-1:0]] <= cmd_q.load_value;
    b_rd_q <= b_mem[n_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DECODE && cmd_q.op == REQ_LOAD_OW && cmd_q.load_ok)
      ow_mem[cmd_q.load_index[OW_AW-1:0]] <= cmd_q.load_value;
    ow_rd_q <= ow_mem[ow_ra];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) ws_mem[st_wa] <= ws_wd;
    ws_rd_q <= ws_mem[st_ra];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) bs_mem[st_wa] <= bs_wd;
    bs_rd_q <= bs_mem[st_ra];
  end

  // ---------------- output layer
  assign d1      = (cfg_i.first_divisor == '0) ? DVS_W'(1) : DVS_W'(cfg_i.first_divisor);
  assign d2      = (cfg_i.second_divisor == '0) ? DVS_W'(1) : cfg_i.second_divisor;
  assign div_num = (state_q == ST_DIV1) ? {{(DIV_W-32){sum_q[31]}}, sum_q} : prod_q;
  assign div_den = (state_q == ST_DIV1) ? d1 : d2;
  assign biased  = $signed(div_q[33:0]) + $signed({{18{cfg_i.out_bias[15]}},
                                                    cfg_i.out_bias});
  assign scaled  = biased * $signed({1'b0, cfg_i.eval_scale});
  assign lim     = DIV_W'(cfg_i.score_limit);
  assign nlim    = DIV_W'(0) - lim;
  assign q2      = div_q;

  always_comb begin
    if ($signed(q2) > $signed(lim))       score_d = lim[15:0];
    else if ($signed(q2) < $signed(nlim)) score_d = nlim[15:0];
    else                                  score_d = q2[15:0];
  end

  nae_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign done_o        = done_q;
  assign score_o       = score_q;
  assign stack_error_o = serr_q;

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(err_q)) else $error("stack error latch cleared");
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_WAIT2)) else $error("result word out of sequence");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop_o |-> !fifo_empty_i) else $error("pop of empty queue");
  a_copy_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && pass_q == PASS_COPY) |-> (top_q == TOP_W'(src_q + 1'b1)))
    else $error("copy source is not the entry below top");
`endif

endmodule

FILE: hdl/nnue_accumulate_and_evaluate_top.sv
// ----------------------------------------------------------------------------
// nnue_accumulate_and_evaluate_top
// Perspective accumulator stack with clamp-squared output layer.
// ----------------------------------------------------------------------------
// A word is taken when start_i is high and busy_o low; busy_o rises only when
// the two-entry command queue is full. Items run one after another in the
// execution engine; feature steps read the white and black rows through the
// single read port of the hidden weight memory. Loads and pops end in decode;
// restart is a bias sweep, an in-range add a feature sweep, push a copy sweep
// plus a feature sweep per enabled in-range feature, evaluate a sweep and the
// two divisions. Evaluate drives done_o for one cycle with score_o and
// stack_error_o; results cannot be held off. No clearing pass after reset.
module nnue_accumulate_and_evaluate_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         req_type_i,
  input  logic [1:0]         move_kind_i,
  input  logic [9:0]         sub_first_i,
  input  logic [9:0]         sub_second_i,
  input  logic [9:0]         add_first_i,
  input  logic [9:0]         add_second_i,
  input  logic               side_to_move_i,
  input  logic [17:0]        load_index_i,
  input  logic signed [15:0] load_value_i,
  output logic               done_o,
  output logic signed [15:0] score_o,
  output logic               stack_error_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [19:0]        cfg_data_i
);
  import nae_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd_in, cmd_out;
  logic fifo_full, fifo_empty, fifo_pop, accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_bias       <= 16'd0;
      cfg_q.clamp_max      <= 15'd255;
      cfg_q.first_divisor  <= 16'd255;
      cfg_q.eval_scale     <= 16'd400;
      cfg_q.second_divisor <= 20'd16320;
      cfg_q.score_limit    <= 15'd31999;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_OUT_BIAS:       cfg_q.out_bias       <= cfg_data_i[15:0];
        CFG_CLAMP_MAX:      cfg_q.clamp_max      <= cfg_data_i[14:0];
        CFG_FIRST_DIVISOR:  cfg_q.first_divisor  <= cfg_data_i[15:0];
        CFG_EVAL_SCALE:     cfg_q.eval_scale     <= cfg_data_i[15:0];
        CFG_SECOND_DIVISOR: cfg_q.second_divisor <= cfg_data_i;
        CFG_SCORE_LIMIT:    cfg_q.score_limit    <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign busy_o = fifo_full;
  assign accept = start_i && !fifo_full;

  nae_front u_front (
    .req_type_i     (req_type_i),
    .move_kind_i    (move_kind_i),
    .sub_first_i    (sub_first_i),
    .sub_second_i   (sub_second_i),
    .add_first_i    (add_first_i),
    .add_second_i   (add_second_i),
    .side_to_move_i (side_to_move_i),
    .load_index_i   (load_index_i),
    .load_value_i   (load_value_i),
    .cmd_o          (cmd_in)
  );

  nae_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .din_i   (cmd_in),
    .pop_i   (fifo_pop),
    .dout_o  (cmd_out),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  nae_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .fifo_empty_i  (fifo_empty),
    .cmd_i         (cmd_out),
    .fifo_pop_o    (fifo_pop),
    .done_o        (done_o),
    .score_o       (score_o),
    .stack_error_o (stack_error_o)
  );

endmodule

FILE: verif/nnue_accumulate_and_evaluate_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nnue_accumulate_and_evaluate_top_test
// Self-checking bench for the perspective accumulator stack and evaluator.
// Loads a small set of feature rows plus all biases and output weights, then
// runs directed words, a stack overflow walk, a register sweep and random
// word streams. An in-bench predictor tracks every store and the stack; each
// done_o strobe is checked against the oldest expected score.
// ----------------------------------------------------------------------------
module nnue_accumulate_and_evaluate_top_test;
  import nae_pkg::*;

  localparam int SETTLE  = 12000;    // queue of two plus one running push, with margin
  localparam int LIMIT   = 8000000;  // cycle budget for the whole run
  localparam int N_FEATS = 8;

  typedef struct {
    req_e        op;
    logic [1:0]  kind;
    logic [9:0]  sub_a, sub_b, add_a, add_b;
    logic        stm;
    logic [17:0] idx;
    logic [15:0] val;
  } word_t;

  typedef struct {
    logic [15:0] score;
    logic        err;
  } score_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         req_type_i = '0;
  logic [1:0]         move_kind_i = '0;
  logic [9:0]         sub_first_i = '0, sub_second_i = '0;
  logic [9:0]         add_first_i = '0, add_second_i = '0;
  logic               side_to_move_i = 1'b0;
  logic [17:0]        load_index_i = '0;
  logic signed [15:0] load_value_i = '0;
  logic               done_o;
  logic signed [15:0] score_o;
  logic               stack_error_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [19:0]        cfg_data_i = '0;

  nnue_accumulate_and_evaluate_top uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  bit [15:0] hw_mem [HW_DEPTH];
  bit [15:0] bias_mem [HID];
  bit [15:0] ow_mem [OW_DEPTH];
  bit [15:0] white_stk [STK_DEPTH_W];
  bit [15:0] black_stk [STK_DEPTH_W];
  int unsigned top_ptr;
  bit          err_latch;
  bit [15:0] r_bias;
  bit [14:0] r_clamp;
  bit [15:0] r_div1;
  bit [15:0] r_scale;
  bit [19:0] r_div2;
  bit [14:0] r_limit;

  score_t      score_q[$];
  int          fails, n_words, n_scores;
  int unsigned cycles;
  bit          no_idle;
  int unsigned feat_set [N_FEATS] = '{0, 63, 100, 383, 384, 500, 767, 447};

  function automatic int unsigned mirror_row(int unsigned f);
    int unsigned c, r;
    c = f / COLOR_STRIDE;
    r = f % COLOR_STRIDE;
    return (1 - c) * COLOR_STRIDE + (r / 64) * 64 + ((r % 64) ^ RANK_FLIP);
  endfunction

  function automatic void apply_feature(int unsigned f, bit add);
    int unsigned wr, br, base;
    if (f >= FEAT) return;
    wr = f;
    br = mirror_row(f);
    base = top_ptr * HID;
    for (int i = 0; i < HID; i++) begin
      if (add) begin
        white_stk[base+i] += hw_mem[wr*HID+i];
        black_stk[base+i] += hw_mem[br*HID+i];
      end else begin
        white_stk[base+i] -= hw_mem[wr*HID+i];
        black_stk[base+i] -= hw_mem[br*HID+i];
      end
    end
  endfunction

  function automatic int unsigned act_term(bit [15:0] n, bit [15:0] w);
    longint v;
    v = longint'($signed(n));
    if (v < 0) v = 0;
    if (v > longint'(r_clamp)) v = longint'(r_clamp);
    return 32'(v * v * longint'($signed(w)));
  endfunction

  function automatic bit [15:0] predict_score(bit stm);
    int unsigned acc, base;
    longint s, d1, d2, lim;
    bit [15:0] own, oth;
    acc = 0;
    base = top_ptr * HID;
    for (int i = 0; i < HID; i++) begin
      own = stm ? black_stk[base+i] : white_stk[base+i];
      oth = stm ? white_stk[base+i] : black_stk[base+i];
      acc += act_term(own, ow_mem[i]);
      acc += act_term(oth, ow_mem[i+HID]);
    end
    s = longint'(int'(acc));
    d1 = (r_div1 == 0) ? 1 : longint'(r_div1);
    d2 = (r_div2 == 0) ? 1 : longint'(r_div2);
    s = s / d1 + longint'($signed(r_bias));
    s = s * longint'(r_scale) / d2;
    lim = longint'(r_limit);
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    return s[15:0];
  endfunction

  function automatic void predict_word(word_t w);
    int unsigned src;
    score_t e;
    case (w.op)
      REQ_LOAD_HW: if (w.idx < HW_DEPTH) hw_mem[w.idx] = w.val;
      REQ_LOAD_B:  if (w.idx < HID) bias_mem[w.idx] = w.val;
      REQ_LOAD_OW: if (w.idx < OW_DEPTH) ow_mem[w.idx] = w.val;
      REQ_RESTART: begin
        top_ptr = 0;
        for (int i = 0; i < HID; i++) begin
          white_stk[i] = bias_mem[i];
          black_stk[i] = bias_mem[i];
        end
      end
      REQ_ADD: apply_feature(w.add_a, 1'b1);
      REQ_PUSH: begin
        if (top_ptr + 1 >= STK) begin
          err_latch = 1'b1;
        end else begin
          src = top_ptr * HID;
          top_ptr++;
          for (int i = 0; i < HID; i++) begin
            white_stk[src+HID+i] = white_stk[src+i];
            black_stk[src+HID+i] = black_stk[src+i];
          end
          apply_feature(w.sub_a, 1'b0);
          if (w.kind != 0) apply_feature(w.sub_b, 1'b0);
          apply_feature(w.add_a, 1'b1);
          if (w.kind[1]) apply_feature(w.add_b, 1'b1);
        end
      end
      REQ_POP: begin
        if (top_ptr == 0) err_latch = 1'b1;
        else top_ptr--;
      end
      default: begin
        e.score = predict_score(w.stm);
        e.err = err_latch;
        score_q.insert(score_q.size(), e);
      end
    endcase
  endfunction

  // called at a rising edge; returns at the edge that took the word
  task automatic send_word(word_t w);
    bit b;
    start_i <= 1'b1;
    req_type_i <= w.op;
    move_kind_i <= w.kind;
    sub_first_i <= w.sub_a;
    sub_second_i <= w.sub_b;
    add_first_i <= w.add_a;
    add_second_i <= w.add_b;
    side_to_move_i <= w.stm;
    load_index_i <= w.idx;
    load_value_i <= w.val;
    do begin
      @(negedge clk_i);
      b = busy_o;
      @(posedge clk_i);
    end while (b);
    predict_word(w);
    n_words++;
  endtask

  task automatic idle_gap();
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic word_t rand_word(req_e op);
    word_t w;
    w.op = op;
    w.kind = 2'($urandom_range(0, 3));
    w.sub_a = 10'($urandom);
    w.sub_b = 10'($urandom);
    w.add_a = 10'($urandom);
    w.add_b = 10'($urandom);
    w.stm = 1'($urandom);
    w.idx = 18'($urandom);
    w.val = 16'($urandom);
    return w;
  endfunction

  // mostly loaded rows, sometimes an out-of-range feature
  function automatic logic [9:0] pick_feat();
    if ($urandom_range(0, 99) < 85) return 10'(feat_set[$urandom_range(0, N_FEATS-1)]);
    return 10'($urandom_range(FEAT, 1023));
  endfunction

  function automatic word_t move_word(logic [1:0] kind);
    word_t w;
    w = rand_word(REQ_PUSH);
    w.kind = kind;
    w.sub_a = pick_feat();
    w.sub_b = pick_feat();
    w.add_a = pick_feat();
    w.add_b = pick_feat();
    return w;
  endfunction

  function automatic word_t load_word(req_e op, int unsigned idx, logic [15:0] val);
    word_t w;
    w = rand_word(op);
    w.idx = 18'(idx);
    w.val = val;
    return w;
  endfunction

  task automatic quiesce();
    start_i <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [19:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_OUT_BIAS:       r_bias = data[15:0];
      CFG_CLAMP_MAX:      r_clamp = data[14:0];
      CFG_FIRST_DIVISOR:  r_div1 = data[15:0];
      CFG_EVAL_SCALE:     r_scale = data[15:0];
      CFG_SECOND_DIVISOR: r_div2 = data[19:0];
      CFG_SCORE_LIMIT:    r_limit = data[14:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] bias, logic [14:0] clamp, logic [15:0] d1,
                           logic [15:0] scale, logic [19:0] d2, logic [14:0] lim);
    write_reg(CFG_OUT_BIAS, 20'(bias));
    write_reg(CFG_CLAMP_MAX, 20'(clamp));
    write_reg(CFG_FIRST_DIVISOR, 20'(d1));
    write_reg(CFG_EVAL_SCALE, 20'(scale));
    write_reg(CFG_SECOND_DIVISOR, d2);
    write_reg(CFG_SCORE_LIMIT, 20'(lim));
  endtask

  task automatic eval_both();
    word_t w;
    w = rand_word(REQ_EVAL);
    w.stm = 1'b0;
    send_word(w);
    w.stm = 1'b1;
    send_word(w);
  endtask

  // output weights, biases and the rows of the feature set and their mirrors
  task automatic test_load_network();
    int unsigned row;
    no_idle = 1'b1;
    for (int i = 0; i < OW_DEPTH; i++) send_word(load_word(REQ_LOAD_OW, i, 16'($urandom)));
    for (int i = 0; i < HID; i++) send_word(load_word(REQ_LOAD_B, i, 16'($urandom)));
    for (int f = 0; f < N_FEATS; f++) begin
      for (int m = 0; m < 2; m++) begin
        row = m ? mirror_row(feat_set[f]) : feat_set[f];
        for (int i = 0; i < HID; i++) begin
          send_word(load_word(REQ_LOAD_HW, row * HID + i, 16'($urandom_range(0, 1023) - 512)));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_directed();
    word_t w;
    send_word(load_word(REQ_LOAD_HW, HW_DEPTH - 1, 16'h8000));
    send_word(load_word(REQ_LOAD_HW, 0, 16'h7fff));
    send_word(load_word(REQ_LOAD_HW, 18'h3ffff, 16'h1234));  // out of range
    send_word(load_word(REQ_LOAD_B, HID, 16'h5555));         // out of range
    send_word(load_word(REQ_LOAD_OW, OW_DEPTH, 16'haaaa));   // out of range
    send_word(rand_word(REQ_RESTART));
    w = rand_word(REQ_ADD);
    w.add_a = 10'd0;
    send_word(w);
    w.add_a = 10'd767;
    send_word(w);
    w.add_a = 10'd1023;  // adds nothing
    send_word(w);
    eval_both();
    for (int k = 0; k < 4; k++) begin  // regular, capture, castling, kind three
      idle_gap();
      send_word(move_word(2'(k)));
    end
    eval_both();
    for (int k = 0; k < 5; k++) send_word(rand_word(REQ_POP));  // last one underflows
    eval_both();
  endtask

  task automatic test_stack_overflow();
    word_t w;
    quiesce();
    send_word(rand_word(REQ_RESTART));
    for (int k = 0; k < STK; k++) begin  // the last push finds the stack full
      w = rand_word(REQ_PUSH);
      w.sub_a = 10'($urandom_range(FEAT, 1023));
      w.sub_b = 10'($urandom_range(FEAT, 1023));
      w.add_a = 10'($urandom_range(FEAT, 1023));
      w.add_b = 10'($urandom_range(FEAT, 1023));
      send_word(w);
      idle_gap();
    end
    eval_both();
    send_word(rand_word(REQ_POP));
    eval_both();
  endtask

  task automatic test_reg_sweep();
    word_t w;
    quiesce();
    send_word(rand_word(REQ_RESTART));
    for (int k = 0; k < 3; k++) send_word(move_word(2'($urandom_range(0, 3))));
    quiesce();
    write_all(16'h8000, 15'd1, 16'd1, 16'hffff, 20'd1, 15'h7fff);
    eval_both();
    quiesce();
    write_all(16'h7fff, 15'h7fff, 16'hffff, 16'd1, 20'hfffff, 15'd1);
    eval_both();
    quiesce();
    write_all(16'd0, 15'd255, 16'd0, 16'd400, 20'd0, 15'd0);  // zero divisors and limit
    eval_both();
    quiesce();
    write_all(16'd0, 15'h7fff, 16'd0, 16'd1, 20'd0, 15'h7fff);
    eval_both();
    quiesce();
    write_all(16'd0, 15'd255, 16'd255, 16'd400, 20'd16320, 15'd31999);
    eval_both();
  endtask

  task automatic test_random(int unsigned n_items);
    word_t w;
    int unsigned r;
    for (int ph = 0; ph < 4; ph++) begin
      quiesce();
      if (ph > 0) begin
        write_all(16'($urandom), 15'($urandom_range(1, 32767)), 16'($urandom_range(1, 65535)),
                  16'($urandom_range(1, 65535)), 20'($urandom_range(1, 1048575)),
                  15'($urandom_range(1, 32767)));
      end
      if (ph == 3) write_reg(CFG_CLAMP_MAX, 20'd255);
      no_idle = (ph == 2);
      send_word(rand_word(REQ_RESTART));
      for (int k = 0; k < n_items / 4; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          w = rand_word(REQ_LOAD_HW);
          if (r < 5) w.idx = 18'(feat_set[$urandom_range(0, N_FEATS-1)] * HID
                              + $urandom_range(0, HID-1));
        end
        else if (r < 16) w = rand_word(REQ_LOAD_B);
        else if (r < 22) w = rand_word(REQ_LOAD_OW);
        else if (r < 25) w = rand_word(REQ_RESTART);
        else if (r < 35) begin
          w = rand_word(REQ_ADD);
          w.add_a = pick_feat();
        end
        else if (r < 60) w = move_word(2'($urandom_range(0, 3)));
        else if (r < 75) w = rand_word(REQ_POP);
        else w = rand_word(REQ_EVAL);
        send_word(w);
        idle_gap();
      end
    end
  endtask

  // results cannot be held off: sample mid-cycle
  always @(negedge clk_i) begin
    score_t e;
    if (rst_ni && done_o) begin
      if (score_q.size() == 0) begin
        $error("score word with nothing expected: score %0d", score_o);
        fails++;
      end else begin
        e = score_q.pop_front();
        n_scores++;
        if (score_o !== e.score) begin
          $error("score: expected %0d, got %0d", $signed(e.score), score_o);
          fails++;
        end
        if (stack_error_o !== e.err) begin
          $error("stack_error: expected %0b, got %0b", e.err, stack_error_o);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    r_bias = 16'd0;
    r_clamp = 15'd255;
    r_div1 = 16'd255;
    r_scale = 16'd400;
    r_div2 = 20'd16320;
    r_limit = 15'd31999;
    top_ptr = 0;
    err_latch = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_network();
    test_directed();
    test_stack_overflow();
    test_reg_sweep();
    test_random(580);
    quiesce();
    $display("%0d words sent, %0d scores checked: loads, moves of all kinds, pops,",
             n_words, n_scores);
    $display("stack overflow and underflow, register extremes and random streams");
    if (fails == 0 && score_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
